FILE: hdl/dccrc_pkg.sv
// ----------------------------------------------------------------------------
// dccrc_pkg
// Shared constants, types and the byte-wide CRC-16 update for the dual-copy
// record checker.
// ----------------------------------------------------------------------------
package dccrc_pkg;

  localparam int unsigned RECORD_BYTES_DEFAULT = 24;

  localparam logic [15:0] CRC_POLY = 16'h8005;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // Copy selection codes on the result
  typedef enum logic [1:0] {
    SEL_FIRST   = 2'd0,
    SEL_SECOND  = 2'd1,
    SEL_NEITHER = 2'd2
  } sel_t;

  // Registered input byte handed to the tracker
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } byte_req_t;

  // Advance one byte through the CRC, MSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: hdl/dccrc_if.sv
// ----------------------------------------------------------------------------
// dccrc_if
// Valid/ready channels of the dual-copy record checker: byte input and
// check result.
// ----------------------------------------------------------------------------
interface dccrc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface dccrc_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  selected_copy;
  logic        first_valid;
  logic        second_valid;
  logic [15:0] first_crc;
  logic [15:0] second_crc;

  modport source (output valid, output selected_copy, output first_valid,
                  output second_valid, output first_crc, output second_crc,
                  input ready);
  modport sink   (input valid, input selected_copy, input first_valid,
                  input second_valid, input first_crc, input second_crc,
                  output ready);
endinterface

FILE: hdl/dual_copy_crc_record_checker_core.sv
// Result path: the last byte of the second copy is held in the input register,
//   then the check result is loaded into the result register.
// Throughput: one byte per cycle; the byte-wide CRC-16 update sits between
//   the two registers, and input stalls only while a result waits on ready.
// Reset: synchronous active-high rst clears both valid flags and restarts at
//   the first byte of the first copy with CRC 0xFFFF.
// ----------------------------------------------------------------------------
// dual_copy_crc_record_checker_core
// Checks two redundant records with CRC-16 and reports which copy to use.
// ----------------------------------------------------------------------------
module dual_copy_crc_record_checker_core #(
  parameter int unsigned RECORD_BYTES = dccrc_pkg::RECORD_BYTES_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  dccrc_byte_if.sink     byte_in,
  dccrc_result_if.source result_out
);
  import dccrc_pkg::*;

  byte_req_t req;
  logic      adv;

  // Register incoming bytes
  dccrc_input_reg u_input_reg (
    .clk     (clk),
    .rst     (rst),
    .byte_in (byte_in),
    .adv     (adv),
    .req     (req)
  );

  // Track copies and produce the result
  dccrc_tracker #(
    .RECORD_BYTES (RECORD_BYTES)
  ) u_tracker (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .adv        (adv),
    .result_out (result_out)
  );

endmodule

FILE: hdl/dccrc_input_reg.sv
// ----------------------------------------------------------------------------
// dccrc_input_reg
// Input register: captures one byte request per cycle and holds it while
// the tracker stage is stalled.
// ----------------------------------------------------------------------------
module dccrc_input_reg (
  input  logic                 clk,
  input  logic                 rst,
  dccrc_byte_if.sink           byte_in,
  input  logic                 adv,
  output dccrc_pkg::byte_req_t req
);
  import dccrc_pkg::*;

  logic accept;

  // Take a new byte when the register is empty or drains this cycle
  assign byte_in.ready = !req.valid || adv;
  assign accept        = byte_in.valid && byte_in.ready;

  // Load, drain or hold the request
  always_ff @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else if (accept) begin
      req.valid <= 1'b1;
    end else if (adv) begin
      req.valid <= 1'b0;
    end
    if (accept) begin
      req.data <= byte_in.data_byte;
    end
  end

  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    accept |=> req.valid)
    else $error("accepted byte not registered");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (req.valid && !adv) |=> (req.valid && $stable(req.data)))
    else $error("stalled byte lost or changed");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !req.valid |-> byte_in.ready)
    else $error("empty input register refuses a byte");

endmodule

FILE: hdl/dccrc_tracker.sv
// ----------------------------------------------------------------------------
// dccrc_tracker
// Record tracker: runs the CRC over each copy, captures the stored CRC,
// compares, and loads the result register after the second copy.
// ----------------------------------------------------------------------------
module dccrc_tracker #(
  parameter int unsigned RECORD_BYTES = dccrc_pkg::RECORD_BYTES_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dccrc_pkg::byte_req_t req,
  output logic                 adv,
  dccrc_result_if.source       result_out
);
  import dccrc_pkg::*;

  localparam int unsigned IDX_W = $clog2(RECORD_BYTES);
  localparam logic [IDX_W-1:0] IDX_LOW  = IDX_W'(RECORD_BYTES - 2);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RECORD_BYTES - 1);

  logic [15:0]      running_crc;
  logic [IDX_W-1:0] idx;
  logic             second;
  logic [7:0]       stored_low_byte;
  logic [15:0]      saved_first_crc;
  logic             saved_first_valid;

  logic             take;
  logic             in_body;
  logic             at_low;
  logic             at_last;
  logic             match;
  logic             done;
  sel_t             sel_next;

  // Stall only while a finished result waits
  assign adv  = !result_out.valid || result_out.ready;
  assign take = adv && req.valid;

  // Decode position and compare against the stored CRC
  assign in_body = idx < IDX_LOW;
  assign at_low  = idx == IDX_LOW;
  assign at_last = idx == IDX_LAST;
  assign match   = running_crc == {req.data, stored_low_byte};
  assign done    = take && at_last && second;

  // Pick the copy to use
  always_comb begin
    if (saved_first_valid) begin
      sel_next = SEL_FIRST;
    end else if (match) begin
      sel_next = SEL_SECOND;
    end else begin
      sel_next = SEL_NEITHER;
    end
  end

  // Advance position, CRC and per-copy state
  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc       <= CRC_INIT;
      idx               <= '0;
      second            <= 1'b0;
      stored_low_byte   <= 8'h00;
      saved_first_crc   <= 16'h0000;
      saved_first_valid <= 1'b0;
    end else if (take) begin
      if (in_body) begin
        running_crc <= crc_byte(running_crc, req.data);
        idx         <= idx + 1'b1;
      end else if (at_low) begin
        stored_low_byte <= req.data;
        idx             <= idx + 1'b1;
      end else begin
        if (!second) begin
          saved_first_crc   <= running_crc;
          saved_first_valid <= match;
        end
        running_crc <= CRC_INIT;
        idx         <= '0;
        second      <= !second;
      end
    end
  end

  // Result register: set on the closing byte, clear once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_out.valid <= 1'b0;
    end else if (adv) begin
      result_out.valid <= done;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      result_out.selected_copy <= sel_next;
      result_out.first_valid   <= saved_first_valid;
      result_out.second_valid  <= match;
      result_out.first_crc     <= saved_first_crc;
      result_out.second_crc    <= running_crc;
    end
  end

  a_done_gives_result: assert property (@(posedge clk) disable iff (rst)
    done |=> result_out.valid)
    else $error("closing byte produced no result");

  a_first_pref: assert property (@(posedge clk) disable iff (rst)
    result_out.valid |->
      ((result_out.selected_copy == SEL_FIRST) == result_out.first_valid))
    else $error("first copy selection disagrees with its good flag");

  a_neither: assert property (@(posedge clk) disable iff (rst)
    (result_out.valid && result_out.selected_copy == SEL_NEITHER) |->
      (!result_out.first_valid && !result_out.second_valid))
    else $error("neither selected although a copy is good");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    idx <= IDX_LAST)
    else $error("byte position beyond record length");

endmodule
